### hdl/nups_pkg.sv
// nups_pkg: shared constants, types and codes for the nearest unvisited point search unit
// no dependencies; imported by every other file of the block
package nups_pkg;

	localparam int MAX_POINTS   = 64;
	localparam int COORD_BITS   = 12;
	localparam int POS_W        = 12;
	localparam int INDEX_W      = 6;
	localparam int RADIUS_W     = 13;
	localparam int RADIUS_RESET = 1000;

	localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int LIM_W  = 2 * RADIUS_W;
	localparam int DIST_W = (SQ_W + 1 > LIM_W) ? SQ_W + 1 : LIM_W;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DIST_W-1:0]     dist_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_FIND,
		OP_CLR_VIS,
		OP_CLR_TAB
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_NONE,
		STAT_FULL
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_MARK,
		ST_DONE
	} state_t;

	// controls shared by every cell of the ring
	typedef struct packed {
		logic shift;
		logic clr_vis;
	} cell_ctl_t;

	// controls into the scan datapath
	typedef struct packed {
		logic start;
		logic valid;
		idx_t idx;
	} scan_ctl_t;

	// best candidate found by the scan
	typedef struct packed {
		logic   found;
		idx_t   idx;
		coord_t x;
		coord_t y;
	} scan_res_t;

endpackage

### hdl/nups_if.sv
// nups_if: valid/ready channel interfaces for requests, responses and the radius register
// depends on nups_pkg
interface nups_req_if;
	import nups_pkg::*;
	logic                   valid;
	logic                   ready;
	op_t                    operation;
	logic [POS_W-1:0]       pos_x;
	logic [POS_W-1:0]       pos_y;
	modport source (output valid, operation, pos_x, pos_y, input ready);
	modport sink (input valid, operation, pos_x, pos_y, output ready);
endinterface

interface nups_rsp_if;
	import nups_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [POS_W-1:0]       point_x;
	logic [POS_W-1:0]       point_y;
	logic [INDEX_W-1:0]     point_index;
	status_t                status;
	modport source (output valid, point_x, point_y, point_index, status, input ready);
	modport sink (input valid, point_x, point_y, point_index, status, output ready);
endinterface

interface nups_cfg_if;
	import nups_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [RADIUS_W-1:0]    data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### hdl/nups_cell.sv
// nups_cell: one waypoint cell of the rotating ring (coordinates and visited mark)
// depends on nups_pkg
module nups_cell
	import nups_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      load_en,
	input  logic      set_vis,
	input  coord_t    load_x,
	input  coord_t    load_y,
	input  coord_t    nxt_x,
	input  coord_t    nxt_y,
	input  logic      nxt_vis,
	output coord_t    x,
	output coord_t    y,
	output logic      vis
);

	coord_t x_q;
	coord_t y_q;
	logic   vis_q;

	// coordinates are undefined until loaded
	always_ff @(posedge clk) begin
		if (load_en) begin
			x_q <= load_x;
			y_q <= load_y;
		end else if (ctl.shift) begin
			x_q <= nxt_x;
			y_q <= nxt_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q <= 1'b0;
		end else if (ctl.clr_vis || load_en) begin
			vis_q <= 1'b0;
		end else if (set_vis) begin
			vis_q <= 1'b1;
		end else if (ctl.shift) begin
			vis_q <= nxt_vis;
		end
	end

	assign x   = x_q;
	assign y   = y_q;
	assign vis = vis_q;

endmodule

### hdl/nups_scan.sv
// nups_scan: squared-distance pipeline and running minimum over the ring head
// depends on nups_pkg
module nups_scan
	import nups_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  scan_ctl_t ctl,
	input  coord_t    pos_x,
	input  coord_t    pos_y,
	input  coord_t    head_x,
	input  coord_t    head_y,
	input  dist_t     limit,
	output scan_res_t res
);

	logic              v_s1;
	idx_t              idx_s1;
	coord_t            x_s1;
	coord_t            y_s1;
	coord_t            dx_s1;
	coord_t            dy_s1;

	logic              v_s2;
	idx_t              idx_s2;
	coord_t            x_s2;
	coord_t            y_s2;
	logic [SQ_W-1:0]   sqx_s2;
	logic [SQ_W-1:0]   sqy_s2;

	dist_t             best_q;
	logic              found_q;
	idx_t              best_idx_q;
	coord_t            best_x_q;
	coord_t            best_y_q;

	coord_t            dx;
	coord_t            dy;
	logic [SQ_W-1:0]   dx_ext;
	logic [SQ_W-1:0]   dy_ext;
	dist_t             sum;

	assign dx = (head_x > pos_x) ? head_x - pos_x : pos_x - head_x;
	assign dy = (head_y > pos_y) ? head_y - pos_y : pos_y - head_y;

	assign dx_ext = SQ_W'(dx_s1);
	assign dy_ext = SQ_W'(dy_s1);

	assign sum = DIST_W'(sqx_s2) + DIST_W'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ctl.idx;
		x_s1   <= head_x;
		y_s1   <= head_y;
		dx_s1  <= dx;
		dy_s1  <= dy;
		idx_s2 <= idx_s1;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		sqx_s2 <= dx_ext * dx_ext;
		sqy_s2 <= dy_ext * dy_ext;
	end

	// strict compare keeps the lowest index on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (v_s2 && (sum < best_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			best_q <= limit;
		end else if (v_s2 && (sum < best_q)) begin
			best_q     <= sum;
			best_idx_q <= idx_s2;
			best_x_q   <= x_s2;
			best_y_q   <= y_s2;
		end
	end

	assign res = '{found: found_q, idx: best_idx_q, x: best_x_q, y: best_y_q};

endmodule

### hdl/nearest_unvisited_point_search_unit.sv
// nearest_unvisited_point_search_unit: top level, ring of waypoint cells, scan datapath, control
// depends on nups_pkg, nups_if, nups_cell, nups_scan
// find: one ring rotation through the single distance unit (scan), then drain, mark and hand-off (done)
// load and clear requests go from idle straight to hand-off, where the result enters the output register
// a new request is accepted only back in idle, once the result of the last one has been handed off
// reset clears point count and visited marks and sets radius to 1000; coordinates undefined until loaded
module nearest_unvisited_point_search_unit
	import nups_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	nups_req_if.sink   req,
	nups_rsp_if.source rsp,
	nups_cfg_if.sink   cfg
);

	// fsm
	state_t state_q;
	state_t state_d;

	// registers
	logic [RADIUS_W-1:0] radius_q;
	cnt_t                count_q;
	idx_t                k_q;
	logic                drain_q;
	coord_t              pos_x_q;
	coord_t              pos_y_q;

	// result waiting for the output register
	logic [POS_W-1:0]    res_x_q;
	logic [POS_W-1:0]    res_y_q;
	logic [INDEX_W-1:0]  res_idx_q;
	status_t             res_stat_q;

	// output register
	logic                out_valid_q;
	logic [POS_W-1:0]    out_x_q;
	logic [POS_W-1:0]    out_y_q;
	logic [INDEX_W-1:0]  out_idx_q;
	status_t             out_stat_q;

	// ring of cells
	coord_t              cell_x [MAX_POINTS];
	coord_t              cell_y [MAX_POINTS];
	logic                cell_vis [MAX_POINTS];
	logic [MAX_POINTS-1:0] load_en;
	logic [MAX_POINTS-1:0] set_vis;
	cell_ctl_t           cell_ctl;

	// scan
	scan_ctl_t           scan_ctl;
	scan_res_t           scan_res;

	// control decode
	logic                accept;
	logic                out_free;
	logic                ld_go;
	logic                room;
	coord_t              in_x;
	coord_t              in_y;
	logic [LIM_W-1:0]    rad_ext;
	logic [LIM_W-1:0]    rad_sq;
	dist_t               limit_sq;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign room     = (count_q < cnt_t'(MAX_POINTS));
	assign ld_go    = accept && (req.operation == OP_LOAD) && room;

	// coordinates masked to the table width
	assign in_x = COORD_BITS'(req.pos_x);
	assign in_y = COORD_BITS'(req.pos_y);

	// squared radius of the current register, taken as the starting best distance of a find
	assign rad_ext  = LIM_W'(radius_q);
	assign rad_sq   = rad_ext * rad_ext;
	assign limit_sq = DIST_W'(rad_sq);

	// next state and fsm outputs
	always_comb begin
		state_d         = state_q;
		req.ready       = 1'b0;
		cell_ctl.shift  = 1'b0;
		cell_ctl.clr_vis = 1'b0;
		scan_ctl.start  = 1'b0;
		scan_ctl.valid  = 1'b0;
		scan_ctl.idx    = k_q;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					unique case (req.operation) inside
						OP_FIND: begin
							scan_ctl.start = 1'b1;
							state_d        = ST_SCAN;
						end
						OP_CLR_VIS, OP_CLR_TAB: begin
							cell_ctl.clr_vis = 1'b1;
							state_d          = ST_DONE;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// ring rotates one place a cycle, entry k_q sits at the head
				cell_ctl.shift = 1'b1;
				scan_ctl.valid = (cnt_t'(k_q) < count_q) && !cell_vis[0];
				if (k_q == idx_t'(MAX_POINTS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q) begin
					state_d = ST_MARK;
				end
			end
			ST_MARK: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// radius register, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_W'(RADIUS_RESET);
		end else if (cfg.valid) begin
			radius_q <= cfg.data;
		end
	end

	// point count and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
			drain_q <= 1'b0;
		end else begin
			if (ld_go) begin
				count_q <= count_q + cnt_t'(1);
			end else if (accept && (req.operation == OP_CLR_TAB)) begin
				count_q <= '0;
			end
			if (state_q == ST_SCAN) begin
				k_q <= (k_q == idx_t'(MAX_POINTS - 1)) ? '0 : k_q + idx_t'(1);
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= !drain_q;
			end
		end
	end

	// request payload held for the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_x_q <= in_x;
			pos_y_q <= in_y;
		end
	end

	// result of the current request; every path leaves zeros where nothing applies
	always_ff @(posedge clk) begin
		if (accept) begin
			res_x_q    <= '0;
			res_y_q    <= '0;
			res_idx_q  <= '0;
			res_stat_q <= STAT_OK;
			if (req.operation == OP_LOAD) begin
				if (room) begin
					res_idx_q <= INDEX_W'(count_q);
				end else begin
					res_stat_q <= STAT_FULL;
				end
			end
		end else if (state_q == ST_MARK) begin
			if (scan_res.found) begin
				res_x_q   <= POS_W'(scan_res.x);
				res_y_q   <= POS_W'(scan_res.y);
				res_idx_q <= INDEX_W'(scan_res.idx);
			end else begin
				res_stat_q <= STAT_NONE;
			end
		end
	end

	// output register, parts the response side from the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_x_q    <= res_x_q;
			out_y_q    <= res_y_q;
			out_idx_q  <= res_idx_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.point_x     = out_x_q;
	assign rsp.point_y     = out_y_q;
	assign rsp.point_index = out_idx_q;
	assign rsp.status      = out_stat_q;

	// ring of cells, each takes its upper neighbour; the last wraps to the head
	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		localparam int NXT = (i + 1) % MAX_POINTS;

		// ring is back in place when a load or a mark happens
		assign load_en[i] = ld_go && (count_q[IDX_W-1:0] == idx_t'(i));
		assign set_vis[i] = (state_q == ST_MARK) && scan_res.found &&
			(scan_res.idx == idx_t'(i));

		nups_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.load_en (load_en[i]),
			.set_vis (set_vis[i]),
			.load_x  (in_x),
			.load_y  (in_y),
			.nxt_x   (cell_x[NXT]),
			.nxt_y   (cell_y[NXT]),
			.nxt_vis (cell_vis[NXT]),
			.x       (cell_x[i]),
			.y       (cell_y[i]),
			.vis     (cell_vis[i])
		);
	end

	// distance unit watches the head of the ring
	nups_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.pos_x  (pos_x_q),
		.pos_y  (pos_y_q),
		.head_x (cell_x[0]),
		.head_y (cell_y[0]),
		.limit  (limit_sq),
		.res    (scan_res)
	);

endmodule

### hdl/nups_checker.sv
// nups_checker: port-level assertions for the nearest unvisited point search unit
// depends on nups_pkg; bound to nearest_unvisited_point_search_unit
module nups_checker
	import nups_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [POS_W-1:0]   rsp_x,
	input logic [POS_W-1:0]   rsp_y,
	input logic [INDEX_W-1:0] rsp_index,
	input status_t            rsp_status,
	input logic               cfg_ready
);

	// failed requests carry only their status
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STAT_NONE || rsp_status == STAT_FULL) |->
		(rsp_x == '0) && (rsp_y == '0) && (rsp_index == '0))
		else $error("failed response carries nonzero payload");

	// a pending response stays valid, with status and index unchanged, until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_index))
		else $error("response dropped or changed while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	// the radius register never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("radius write stalled");

endmodule

bind nearest_unvisited_point_search_unit nups_checker u_nups_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_x      (rsp.point_x),
	.rsp_y      (rsp.point_y),
	.rsp_index  (rsp.point_index),
	.rsp_status (rsp.status),
	.cfg_ready  (cfg.ready)
);
